// ===== rtl/rme_pkg.sv =====
package rme_pkg;

  // Matrix elements, Q1.30
  localparam int unsigned ELEM_W  = 32;
  // Output angles, Q3.28
  localparam int unsigned ANGLE_W = 31;
  // CORDIC operand width after sign extension and negation
  localparam int unsigned OP_W    = 34;
  // Fraction guard bits added ahead of the rotations
  localparam int unsigned GUARD_W = 20;
  // Datapath width: operand + guard + headroom for the CORDIC gain
  localparam int unsigned CORD_W  = OP_W + GUARD_W + 2;
  // Angle accumulator width
  localparam int unsigned ACC_W   = 32;
  // Width of one arctangent table entry
  localparam int unsigned ATAN_W  = 28;
  // Root bits produced by the square root, one per step
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned SQ_W     = 2 * SQ_STEPS;

  localparam logic signed [ACC_W-1:0] PI_Q28 = 32'sd843314857;

  typedef struct packed {
    logic signed [ELEM_W-1:0] r00;
    logic signed [ELEM_W-1:0] r10;
    logic signed [ELEM_W-1:0] r20;
    logic signed [ELEM_W-1:0] r21;
    logic signed [ELEM_W-1:0] r22;
    logic signed [ELEM_W-1:0] r11;
    logic signed [ELEM_W-1:0] r12;
  } mat_t;

  // atan(2^-idx) in Q3.28, rounded to nearest
  function automatic logic [ATAN_W-1:0] atan_q28(input logic [4:0] idx);
    logic [ATAN_W-1:0] v;
    unique case (idx)
      5'd0:    v = 28'd210828714;
      5'd1:    v = 28'd124459457;
      5'd2:    v = 28'd65760959;
      5'd3:    v = 28'd33381290;
      5'd4:    v = 28'd16755422;
      5'd5:    v = 28'd8385879;
      5'd6:    v = 28'd4193963;
      5'd7:    v = 28'd2097109;
      5'd8:    v = 28'd1048571;
      5'd9:    v = 28'd524287;
      5'd10:   v = 28'd262144;
      5'd11:   v = 28'd131072;
      5'd12:   v = 28'd65536;
      5'd13:   v = 28'd32768;
      5'd14:   v = 28'd16384;
      5'd15:   v = 28'd8192;
      5'd16:   v = 28'd4096;
      5'd17:   v = 28'd2048;
      5'd18:   v = 28'd1024;
      5'd19:   v = 28'd512;
      5'd20:   v = 28'd256;
      5'd21:   v = 28'd128;
      5'd22:   v = 28'd64;
      5'd23:   v = 28'd32;
      5'd24:   v = 28'd16;
      5'd25:   v = 28'd8;
      5'd26:   v = 28'd4;
      5'd27:   v = 28'd2;
      5'd28:   v = 28'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rme_sqrt.sv =====
// Squares, sum and a 32-step restoring square root, one root bit per stage.
// The matrix rides alongside so it leaves together with its sy.
module rme_sqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  rme_pkg::mat_t                   mat_i,
  output logic                            valid_o,
  output logic [rme_pkg::SQ_STEPS-1:0]    sy_o,
  output rme_pkg::mat_t                   mat_o
);

  localparam int unsigned Steps = rme_pkg::SQ_STEPS;
  localparam int unsigned SqW   = rme_pkg::SQ_W;
  localparam int unsigned Lat   = Steps + 2;

  logic                   v_q   [0:Lat-1];
  rme_pkg::mat_t          mat_q [0:Lat-1];
  logic signed [SqW-1:0]  sq0_q;
  logic signed [SqW-1:0]  sq1_q;
  logic [SqW-1:0]         rem_q  [0:Steps-1];
  logic [SqW-1:0]         root_q [1:Steps];

  // stage 0: the two squares
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
      v_q[1] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    sq0_q    <= SqW'(mat_i.r00) * SqW'(mat_i.r00);
    sq1_q    <= SqW'(mat_i.r10) * SqW'(mat_i.r10);
    mat_q[0] <= mat_i;
    // stage 1: sum, at most 2^63
    rem_q[0] <= $unsigned(sq0_q) + $unsigned(sq1_q);
    mat_q[1] <= mat_q[0];
  end

  for (genvar j = 0; j < Steps; j++) begin : g_step
    localparam int unsigned Pos = 2 * (Steps - 1 - j);
    logic [SqW-1:0] root_in;
    logic [SqW-1:0] bit_v;
    logic [SqW-1:0] trial;
    logic           ge;

    if (j == 0) begin : g_first
      assign root_in = '0;
    end else begin : g_next
      assign root_in = root_q[j];
    end

    assign bit_v = SqW'(1) << Pos;
    assign trial = root_in + bit_v;
    assign ge    = (rem_q[j] >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+2] <= 1'b0;
      end else begin
        v_q[j+2] <= v_q[j+1];
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[j+1] <= ge ? ((root_in >> 1) + bit_v) : (root_in >> 1);
      mat_q[j+2]  <= mat_q[j+1];
    end

    // the remainder of the last step is never needed
    if (j < Steps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[j+1] <= ge ? (rem_q[j] - trial) : rem_q[j];
      end
    end
  end

  assign valid_o = v_q[Lat-1];
  assign sy_o    = root_q[Steps][Steps-1:0];
  assign mat_o   = mat_q[Lat-1];

endmodule

// ===== rtl/rme_cordic.sv =====
// Vectoring CORDIC atan2(y, x): quadrant fold, N rotation stages, clamp.
// One new operand pair per cycle.
module rme_cordic #(
  parameter int unsigned N = 28
) (
  input  logic                                 clk_i,
  input  logic signed [rme_pkg::OP_W-1:0]      y_i,
  input  logic signed [rme_pkg::OP_W-1:0]      x_i,
  output logic signed [rme_pkg::ANGLE_W-1:0]   angle_o
);

  localparam int unsigned CW = rme_pkg::CORD_W;
  localparam int unsigned ZW = rme_pkg::ACC_W;

  logic signed [CW-1:0] x_q [0:N];
  logic signed [CW-1:0] y_q [0:N];
  logic signed [ZW-1:0] z_q [0:N];
  logic                 zy_q [0:N];   // y was zero: exact answer
  logic                 xn_q [0:N];   // x was negative

  logic signed [rme_pkg::OP_W-1:0] x_fold;
  logic signed [rme_pkg::OP_W-1:0] y_fold;
  logic signed [ZW-1:0]            z_init;

  // fold the left half-plane onto the right, starting at +-pi
  always_comb begin
    if (x_i[rme_pkg::OP_W-1]) begin
      x_fold = -x_i;
      y_fold = -y_i;
      z_init = y_i[rme_pkg::OP_W-1] ? -rme_pkg::PI_Q28 : rme_pkg::PI_Q28;
    end else begin
      x_fold = x_i;
      y_fold = y_i;
      z_init = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= CW'(x_fold) <<< rme_pkg::GUARD_W;
    y_q[0]  <= CW'(y_fold) <<< rme_pkg::GUARD_W;
    z_q[0]  <= z_init;
    zy_q[0] <= (y_i == '0);
    xn_q[0] <= x_i[rme_pkg::OP_W-1];
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [CW-1:0]          xs;
    logic signed [CW-1:0]          ys;
    logic [rme_pkg::ATAN_W-1:0]    at;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = rme_pkg::atan_q28(5'(i));

    always_ff @(posedge clk_i) begin
      if (!y_q[i][CW-1]) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + $signed(ZW'(at));
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - $signed(ZW'(at));
      end
      zy_q[i+1] <= zy_q[i];
      xn_q[i+1] <= xn_q[i];
    end
  end

  logic signed [ZW-1:0] ang_d;

  always_comb begin
    priority if (zy_q[N]) begin
      ang_d = xn_q[N] ? rme_pkg::PI_Q28 : '0;
    end else if (z_q[N] > rme_pkg::PI_Q28) begin
      ang_d = rme_pkg::PI_Q28;
    end else if (z_q[N] < -rme_pkg::PI_Q28) begin
      ang_d = -rme_pkg::PI_Q28;
    end else begin
      ang_d = z_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_o <= rme_pkg::ANGLE_W'(ang_d);
  end

endmodule

// ===== rtl/rotation_matrix_to_euler.sv =====
// Channel   | Direction | Signals                                  | Beat taken when
// ----------+-----------+------------------------------------------+------------------------
// matrix    | in        | start, busy, r00_i..r12_i                | start && !busy
// result    | out       | done_o, angle_x_o/y_o/z_o, is_singular_o | done_o (single cycle)
// config    | in        | cfg_valid_i, cfg_ready_o, cfg_data_i     | cfg_valid_i && cfg_ready_o
//
// One matrix per cycle; busy stays low, so every start is taken.
// The pipe runs through the squares and their sum, the bit-per-stage
// square root, the threshold compare and operand select, and then the
// three parallel CORDIC pipes.
// rst_ni clears the valid chain and sets the threshold to 1074; no sweep.
// The receiver cannot stall: each result shows for exactly one cycle.
module rotation_matrix_to_euler #(
  parameter int unsigned CORDIC_STAGES = 28
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // matrix beat
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r00_i,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r10_i,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r20_i,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r21_i,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r22_i,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r11_i,
  input  logic signed [rme_pkg::ELEM_W-1:0]    r12_i,
  // singularity threshold write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [30:0]                          cfg_data_i,
  // result beat
  output logic                                 done_o,
  output logic signed [rme_pkg::ANGLE_W-1:0]   angle_x_o,
  output logic signed [rme_pkg::ANGLE_W-1:0]   angle_y_o,
  output logic signed [rme_pkg::ANGLE_W-1:0]   angle_z_o,
  output logic                                 is_singular_o
);

  localparam int unsigned OpW   = rme_pkg::OP_W;
  localparam int unsigned CorLat = CORDIC_STAGES + 2;

  // The pipeline never stalls, so the handshakes are always open.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Threshold register (Q1.30, unsigned)
  // ---------------------------------------------------------------------
  logic [30:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 31'd1074;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------
  // sy = floor(sqrt(r00^2 + r10^2)), matrix carried alongside
  // ---------------------------------------------------------------------
  rme_pkg::mat_t                     mat_in;
  rme_pkg::mat_t                     sq_mat;
  logic                              sq_valid;
  logic [rme_pkg::SQ_STEPS-1:0]      sq_sy;

  assign mat_in = '{r00: r00_i, r10: r10_i, r20: r20_i, r21: r21_i,
                    r22: r22_i, r11: r11_i, r12: r12_i};

  rme_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .mat_i   (mat_in),
    .valid_o (sq_valid),
    .sy_o    (sq_sy),
    .mat_o   (sq_mat)
  );

  // ---------------------------------------------------------------------
  // Singularity decision and operand select. Gimbal lock swaps the x
  // angle onto (-r12, r11); z is forced to zero at the output.
  // ---------------------------------------------------------------------
  logic                  sel_vld_q;
  logic                  sel_sing_q;
  logic signed [OpW-1:0] xa_y_q, xa_x_q;
  logic signed [OpW-1:0] ya_y_q, ya_x_q;
  logic signed [OpW-1:0] za_y_q, za_x_q;
  logic                  sing_d;

  assign sing_d = (sq_sy < {1'b0, thr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_vld_q <= 1'b0;
    end else begin
      sel_vld_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_sing_q <= sing_d;
    ya_y_q     <= -OpW'(sq_mat.r20);
    ya_x_q     <= $signed(OpW'(sq_sy));
    za_y_q     <= OpW'(sq_mat.r10);
    za_x_q     <= OpW'(sq_mat.r00);
    if (sing_d) begin
      xa_y_q <= -OpW'(sq_mat.r12);
      xa_x_q <= OpW'(sq_mat.r11);
    end else begin
      xa_y_q <= OpW'(sq_mat.r21);
      xa_x_q <= OpW'(sq_mat.r22);
    end
  end

  // ---------------------------------------------------------------------
  // Three atan2 pipes in lockstep
  // ---------------------------------------------------------------------
  logic signed [rme_pkg::ANGLE_W-1:0] ang_x, ang_y, ang_z;

  rme_cordic #(.N(CORDIC_STAGES)) u_cordic_x (
    .clk_i   (clk_i),
    .y_i     (xa_y_q),
    .x_i     (xa_x_q),
    .angle_o (ang_x)
  );

  rme_cordic #(.N(CORDIC_STAGES)) u_cordic_y (
    .clk_i   (clk_i),
    .y_i     (ya_y_q),
    .x_i     (ya_x_q),
    .angle_o (ang_y)
  );

  rme_cordic #(.N(CORDIC_STAGES)) u_cordic_z (
    .clk_i   (clk_i),
    .y_i     (za_y_q),
    .x_i     (za_x_q),
    .angle_o (ang_z)
  );

  // valid and singular flag follow the CORDIC latency
  logic [CorLat-1:0] vld_pipe_q;
  logic [CorLat-1:0] sing_pipe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_pipe_q <= '0;
    end else begin
      vld_pipe_q <= {vld_pipe_q[CorLat-2:0], sel_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    sing_pipe_q <= {sing_pipe_q[CorLat-2:0], sel_sing_q};
  end

  assign done_o        = vld_pipe_q[CorLat-1];
  assign is_singular_o = sing_pipe_q[CorLat-1];
  assign angle_x_o     = ang_x;
  assign angle_y_o     = ang_y;
  assign angle_z_o     = sing_pipe_q[CorLat-1] ? '0 : ang_z;

endmodule

// ===== rtl/rme_chk.sv =====
// Port-level checks for rotation_matrix_to_euler.
module rme_chk #(
  parameter int unsigned CORDIC_STAGES = 28
) (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input logic signed [rme_pkg::ANGLE_W-1:0]   angle_x_o,
  input logic signed [rme_pkg::ANGLE_W-1:0]   angle_y_o,
  input logic signed [rme_pkg::ANGLE_W-1:0]   angle_z_o,
  input logic                                 is_singular_o
);

  // beat in to beat out
  localparam int unsigned Lat = CORDIC_STAGES + 37;

  localparam logic signed [rme_pkg::ANGLE_W-1:0] PiA =
    rme_pkg::ANGLE_W'(rme_pkg::PI_Q28);

  // every result beat has an input beat a fixed time before it
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, Lat))
    else $error("result beat without an input beat Lat cycles back");

  // every accepted beat comes out
  a_no_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start && !busy && rst_ni, Lat) |-> done_o)
    else $error("input beat produced no result beat Lat cycles later");

  a_sing_z : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && is_singular_o |-> angle_z_o == '0)
    else $error("singular result with nonzero z angle");

  a_x_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_x_o <= PiA) && (angle_x_o >= -PiA))
    else $error("x angle outside +-pi");

  a_yz_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (angle_y_o <= PiA) && (angle_y_o >= -PiA) &&
               (angle_z_o <= PiA) && (angle_z_o >= -PiA))
    else $error("y or z angle outside +-pi");

endmodule

bind rotation_matrix_to_euler rme_chk #(.CORDIC_STAGES(CORDIC_STAGES)) u_rme_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .angle_x_o     (angle_x_o),
  .angle_y_o     (angle_y_o),
  .angle_z_o     (angle_z_o),
  .is_singular_o (is_singular_o)
);

// ===== tb/tb_rotation_matrix_to_euler.sv =====
module tb_rotation_matrix_to_euler;

  // Must match the DUT parameter; the model below runs the same number of rotations
  localparam int unsigned CORDIC_N    = 28;
  localparam int unsigned STAGES_RUN  = (CORDIC_N > 32) ? 32 : CORDIC_N;
  // Pipeline depth per the block header: squares, root, select, CORDIC pipes
  localparam int unsigned LATENCY     = CORDIC_N + 37;
  // Slowest run is ~1.3k beats with short gaps plus a drain per phase;
  // this leaves plenty of margin
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam longint PI_RAD = 843314857;
  localparam longint GUARD  = 1048576;   // 2^20 scale: 20 fraction guard bits

  localparam logic [30:0] THR_RESET = 31'd1074;
  localparam logic [30:0] THR_MAX   = 31'h7FFF_FFFF;
  localparam logic [30:0] THR_ONE   = 31'h4000_0000;

  localparam logic signed [rme_pkg::ELEM_W-1:0] ONE      = 32'sh4000_0000;
  localparam logic signed [rme_pkg::ELEM_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [rme_pkg::ELEM_W-1:0] MOST_POS = 32'sh7FFF_FFFF;

  // How random matrix elements are drawn
  typedef enum int {
    GEN_FULL,   // any 32-bit pattern
    GEN_UNIT,   // within the Q1.30 unit range
    GEN_NEAR    // r00/r10 scaled around the threshold, rest unit range
  } gen_mode_e;

  typedef struct packed {
    logic signed [rme_pkg::ANGLE_W-1:0] ax;
    logic signed [rme_pkg::ANGLE_W-1:0] ay;
    logic signed [rme_pkg::ANGLE_W-1:0] az;
    logic                               singular;
  } euler_t;

  // atan(2^-i) in Q3.28, rounded to nearest
  longint atan_lut [32] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [rme_pkg::ELEM_W-1:0] r00_i, r10_i, r20_i, r21_i, r22_i, r11_i, r12_i;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [30:0] cfg_data_i;
  logic done_o;
  logic signed [rme_pkg::ANGLE_W-1:0] angle_x_o, angle_y_o, angle_z_o;
  logic is_singular_o;

  // Threshold the block holds right now, tracked from our own writes
  logic [30:0] sing_threshold = THR_RESET;
  // Angles still owed by the pipe, oldest first
  euler_t expected_angles[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  rotation_matrix_to_euler #(
    .CORDIC_STAGES(CORDIC_N)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .r00_i         (r00_i),
    .r10_i         (r10_i),
    .r20_i         (r20_i),
    .r21_i         (r21_i),
    .r22_i         (r22_i),
    .r11_i         (r11_i),
    .r12_i         (r12_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .angle_x_o     (angle_x_o),
    .angle_y_o     (angle_y_o),
    .angle_z_o     (angle_z_o),
    .is_singular_o (is_singular_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_angles.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Angle predictor
  // ---------------------------------------------------------------------------

  // Bit-pair integer square root, floor
  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, b;
    rem  = v;
    root = '0;
    b    = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem  = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[31:0];
  endfunction

  // atan2(y, x) by vectoring rotations, Q3.28 radians, clamped to +-pi
  function automatic longint vector_angle(input longint y_in, input longint x_in);
    longint x, y, xs, ys, z;
    // exact answer on the x axis, origin included
    if (y_in == 0) return (x_in < 0) ? PI_RAD : 0;
    x = x_in;
    y = y_in;
    z = 0;
    // left half plane: flip the vector and start from +-pi
    if (x < 0) begin
      z = (y >= 0) ? PI_RAD : -PI_RAD;
      x = -x;
      y = -y;
    end
    x = x * GUARD;
    y = y * GUARD;
    for (int i = 0; i < STAGES_RUN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_lut[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_lut[i];
      end
    end
    if (z > PI_RAD) z = PI_RAD;
    if (z < -PI_RAD) z = -PI_RAD;
    return z;
  endfunction

  function automatic euler_t predict_euler(input rme_pkg::mat_t m, input logic [30:0] thr);
    longint e00, e10, e20, e21, e22, e11, e12, sy, ax, ay, az;
    logic [63:0] sum_sq;
    euler_t res;
    e00 = longint'(m.r00);
    e10 = longint'(m.r10);
    e20 = longint'(m.r20);
    e21 = longint'(m.r21);
    e22 = longint'(m.r22);
    e11 = longint'(m.r11);
    e12 = longint'(m.r12);
    // up to 2^63 for two -2^31 elements: keep the sum unsigned
    sum_sq = 64'(e00 * e00) + 64'(e10 * e10);
    sy = longint'(floor_sqrt(sum_sq));
    res.singular = (sy < longint'(thr));
    ay = vector_angle(-e20, sy);
    if (!res.singular) begin
      ax = vector_angle(e21, e22);
      az = vector_angle(e10, e00);
    end else begin
      // gimbal lock: roll from the second row, yaw pinned to zero
      ax = vector_angle(-e12, e11);
      az = 0;
    end
    res.ax = ax[rme_pkg::ANGLE_W-1:0];
    res.ay = ay[rme_pkg::ANGLE_W-1:0];
    res.az = az[rme_pkg::ANGLE_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: sampled mid-cycle, the strobe is up for one cycle only
  // ---------------------------------------------------------------------------

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= 10)
        $display("cycle %0d: %s expected %0d, got %0d", cycle_count, what, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    euler_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (expected_angles.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("cycle %0d: result beat with none outstanding", cycle_count);
      end else begin
        want = expected_angles.pop_front();
        check_field("angle_x", longint'(want.ax), longint'(angle_x_o));
        check_field("angle_y", longint'(want.ay), longint'(angle_y_o));
        check_field("angle_z", longint'(want.az), longint'(angle_z_o));
        check_field("is_singular", longint'(want.singular), longint'(is_singular_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rme_pkg::mat_t matrix_of(
      input logic signed [rme_pkg::ELEM_W-1:0] a00, a10, a20, a21, a22, a11, a12);
    rme_pkg::mat_t m;
    m.r00 = a00;
    m.r10 = a10;
    m.r20 = a20;
    m.r21 = a21;
    m.r22 = a22;
    m.r11 = a11;
    m.r12 = a12;
    return m;
  endfunction

  function automatic logic signed [rme_pkg::ELEM_W-1:0] random_elem(
      input gen_mode_e mode, input int unsigned span);
    // zeros now and then, to land on the axes
    if ($urandom_range(0, 7) == 0) return '0;
    unique case (mode)
      GEN_FULL: return $urandom();
      GEN_UNIT: return $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
      default:  return $urandom_range(2 * span, 0) - span;
    endcase
  endfunction

  function automatic rme_pkg::mat_t random_matrix(input gen_mode_e mode,
                                                  input int unsigned span);
    gen_mode_e rest;
    rest = (mode == GEN_NEAR) ? GEN_UNIT : mode;
    return matrix_of(random_elem(mode, span), random_elem(mode, span),
                     random_elem(rest, span), random_elem(rest, span),
                     random_elem(rest, span), random_elem(rest, span),
                     random_elem(rest, span));
  endfunction

  // One matrix beat. Called at a rising edge, returns at the edge that took it.
  // busy is looked at mid-cycle so the take decision never races the DUT.
  task automatic send_matrix(input rme_pkg::mat_t m);
    logic taken;
    start <= 1'b1;
    r00_i <= m.r00;
    r10_i <= m.r10;
    r20_i <= m.r20;
    r21_i <= m.r21;
    r22_i <= m.r22;
    r11_i <= m.r11;
    r12_i <= m.r12;
    do begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end while (!taken);
    expected_angles.insert(expected_angles.size(), predict_euler(m, sing_threshold));
  endtask

  // Threshold write, only with the pipe empty
  task automatic write_threshold(input logic [30:0] value);
    logic taken;
    start <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    cfg_valid_i    <= 1'b0;
    sing_threshold = value;
  endtask

  // Random beats in bursts; some bursts run into the next without a gap
  task automatic run_stream(input int n, input gen_mode_e mode, input int unsigned span);
    int sent, burst, gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_matrix(random_matrix(mode, span));
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset threshold of 1074, straddled from both sides
  task automatic check_reset_threshold();
    send_matrix(matrix_of(32'sd1074, 0, 0, 0, ONE, ONE, 0));
    send_matrix(matrix_of(32'sd1073, 0, 0, 0, ONE, ONE, 0));
    send_matrix(matrix_of(32'sd759, 32'sd760, 0, 0, ONE, ONE, 0));  // sy floors to 1074
    send_matrix(matrix_of(-32'sd1073, 0, ONE, ONE, 0, -ONE, ONE));
  endtask

  // Field extremes, quadrant edges and gimbal lock at the reset threshold
  task automatic check_corner_matrices();
    send_matrix(matrix_of(0, 0, 0, 0, 0, 0, 0));               // atan2(0, 0) throughout
    send_matrix(matrix_of(ONE, 0, 0, 0, ONE, ONE, 0));         // identity
    send_matrix(matrix_of(ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_matrix(matrix_of(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE));
    send_matrix(matrix_of(MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG,
                          MOST_NEG));
    send_matrix(matrix_of(MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS, MOST_POS,
                          MOST_POS));
    send_matrix(matrix_of(-ONE, 0, 0, 0, ONE, ONE, 0));        // yaw exactly pi
    send_matrix(matrix_of(-ONE, -32'sd5, 0, 0, ONE, ONE, 0));  // yaw starts from -pi
    send_matrix(matrix_of(ONE, 0, 0, 0, -ONE, ONE, 0));        // roll exactly pi
    send_matrix(matrix_of(0, 0, -ONE, ONE, 0, 0, -ONE));       // gimbal lock, pitch up
    send_matrix(matrix_of(0, 0, ONE, -ONE, 0, 0, ONE));        // gimbal lock, pitch down
    send_matrix(matrix_of(0, 0, ONE, 0, 0, -ONE, 0));          // locked, fallback roll pi
    send_matrix(matrix_of(ONE, -ONE, MOST_POS, MOST_NEG, -ONE, ONE, MOST_NEG));
  endtask

  // Threshold at zero, at 1.0 and at the 31-bit ceiling
  task automatic check_threshold_limits();
    write_threshold('0);
    send_matrix(matrix_of(0, 0, 0, 32'sd3, -32'sd7, ONE, 0));  // sy of zero still not below
    send_matrix(matrix_of(32'sd1, 0, ONE, 0, ONE, 0, ONE));
    write_threshold(THR_MAX);
    send_matrix(matrix_of(MOST_POS, 0, -ONE, ONE, ONE, ONE, ONE));
    send_matrix(matrix_of(32'sh7FFF_FFFE, 0, -ONE, ONE, ONE, ONE, ONE));
    write_threshold(THR_ONE);
    send_matrix(matrix_of(ONE, 0, ONE, -ONE, ONE, -ONE, -ONE));
    send_matrix(matrix_of(ONE - 32'sd1, 0, ONE, -ONE, ONE, -ONE, -ONE));
  endtask

  // Random phases, a new threshold for each
  task automatic check_random_streams();
    logic [30:0] thr;
    write_threshold(31'($urandom_range(0, 32'h4000_0000)));
    run_stream(300, GEN_UNIT, 0);

    thr = 31'($urandom_range(1, 1 << 20));
    write_threshold(thr);
    run_stream(300, GEN_NEAR, thr + thr / 2);

    write_threshold(31'($urandom()));
    run_stream(250, GEN_FULL, 0);

    thr = 31'($urandom_range(1 << 24, 1 << 30));
    write_threshold(thr);
    run_stream(250, GEN_NEAR, thr + thr / 2);

    write_threshold(THR_RESET);
    run_stream(200, GEN_NEAR, 2048);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    r00_i       <= '0;
    r10_i       <= '0;
    r20_i       <= '0;
    r21_i       <= '0;
    r22_i       <= '0;
    r11_i       <= '0;
    r12_i       <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    check_reset_threshold();
    check_corner_matrices();
    check_threshold_limits();
    check_random_streams();

    // drain, then a pipe's worth of quiet to catch stray result beats
    start <= 1'b0;
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
